// ----- design/hesc_pkg.sv -----
// Package with the byte codes, command format and entity tables of the HTML escape encoder.
`timescale 1ns / 1ps

package hesc_pkg;

    // Width of the held-back space count.
    localparam int SPACE_W = 6;

    // Character codes.
    localparam logic [7:0] CHR_NUL    = 8'h00;
    localparam logic [7:0] CHR_SPACE  = 8'h20;
    localparam logic [7:0] CHR_QUOTE  = 8'h22;
    localparam logic [7:0] CHR_HASH   = 8'h23;
    localparam logic [7:0] CHR_AMP    = 8'h26;
    localparam logic [7:0] CHR_APOS   = 8'h27;
    localparam logic [7:0] CHR_LPAREN = 8'h28;
    localparam logic [7:0] CHR_RPAREN = 8'h29;
    localparam logic [7:0] CHR_SEMI   = 8'h3B;
    localparam logic [7:0] CHR_LT     = 8'h3C;
    localparam logic [7:0] CHR_GT     = 8'h3E;
    localparam logic [7:0] CHR_LOW_G  = 8'h67;
    localparam logic [7:0] CHR_LOW_L  = 8'h6C;
    localparam logic [7:0] CHR_LOW_T  = 8'h74;
    localparam logic [7:0] CHR_DIG_0  = 8'h30;
    localparam logic [7:0] CHR_DIG_1  = 8'h31;
    localparam logic [7:0] CHR_DIG_3  = 8'h33;
    localparam logic [7:0] CHR_DIG_4  = 8'h34;
    localparam logic [7:0] CHR_DIG_5  = 8'h35;
    localparam logic [7:0] CHR_DIG_8  = 8'h38;
    localparam logic [7:0] CHR_DIG_9  = 8'h39;

    // Command kinds passed from the front end to the back end.
    localparam logic [1:0] CMD_PLAIN  = 2'd0;
    localparam logic [1:0] CMD_ENTITY = 2'd1;
    localparam logic [1:0] CMD_END    = 2'd2;

    // One queued command: spaces to send first, then the byte or its entity.
    typedef struct packed {
        logic [1:0]         kind;
        logic [SPACE_W-1:0] spaces;
        logic [7:0]         data;
    } cmd_t;

    // True for the bytes that are replaced by an entity.
    function automatic logic is_special(input logic [7:0] c);
        logic r;
        begin
            case (c)
                CHR_QUOTE, CHR_LPAREN, CHR_RPAREN, CHR_HASH,
                CHR_AMP, CHR_APOS, CHR_LT, CHR_GT: r = 1'b1;
                default: r = 1'b0;
            endcase
            return r;
        end
    endfunction

    // Number of bytes in the entity of a special byte.
    function automatic logic [2:0] entity_len(input logic [7:0] c);
        logic [2:0] r;
        begin
            case (c)
                CHR_LT, CHR_GT: r = 3'd4;
                default: r = 3'd5;
            endcase
            return r;
        end
    endfunction

    // Byte at position idx of the entity of a special byte.
    function automatic logic [7:0] entity_byte(input logic [7:0] c, input logic [2:0] idx);
        logic [7:0] tens;
        logic [7:0] ones;
        logic [7:0] r;
        begin
            tens = CHR_DIG_3;
            ones = CHR_DIG_4;
            case (c)
                CHR_QUOTE:  begin tens = CHR_DIG_3; ones = CHR_DIG_4; end
                CHR_LPAREN: begin tens = CHR_DIG_4; ones = CHR_DIG_0; end
                CHR_RPAREN: begin tens = CHR_DIG_4; ones = CHR_DIG_1; end
                CHR_HASH:   begin tens = CHR_DIG_3; ones = CHR_DIG_5; end
                CHR_AMP:    begin tens = CHR_DIG_3; ones = CHR_DIG_8; end
                CHR_APOS:   begin tens = CHR_DIG_3; ones = CHR_DIG_9; end
                default:    begin tens = CHR_DIG_3; ones = CHR_DIG_4; end
            endcase
            if (c == CHR_LT || c == CHR_GT)
            begin
                case (idx)
                    3'd0: r = CHR_AMP;
                    3'd1: r = (c == CHR_LT) ? CHR_LOW_L : CHR_LOW_G;
                    3'd2: r = CHR_LOW_T;
                    default: r = CHR_SEMI;
                endcase
            end
            else
            begin
                case (idx)
                    3'd0: r = CHR_AMP;
                    3'd1: r = CHR_HASH;
                    3'd2: r = tens;
                    3'd3: r = ones;
                    default: r = CHR_SEMI;
                endcase
            end
            return r;
        end
    endfunction

endpackage

// ----- design/hesc_in_if.sv -----
// Input channel interface: one string byte per transaction.
`timescale 1ns / 1ps

interface hesc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

// ----- design/hesc_out_if.sv -----
// Output channel interface: one encoded byte per transaction with its flags.
`timescale 1ns / 1ps

interface hesc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_end;

    modport source (output valid, output out_byte, output run_last, output string_end,
                    input ready);
    modport sink (input valid, input out_byte, input run_last, input string_end,
                  output ready);
endinterface

// ----- design/html_escape_trim_encoder_top.sv -----
// Top level of the HTML escape encoder with trailing-space trimming.
//
// Channel  Role    Payload                              Transaction
// in_ch    sink    in_byte[7:0]                         valid && ready
// out_ch   source  out_byte[7:0], run_last, string_end  valid && ready
//
// A byte is taken every cycle while the command queue has room; a space only
// updates the held-back count. The back end sends one byte per cycle from its
// output register while out_ch is ready: a plain byte as itself, an entity as
// 4 or 5 bytes, each after its held-back spaces. Reset clears the space count,
// the queue and the output valid. Up to QUEUE_DEPTH commands buffer a stall
// on the output side before the input side stalls.
`timescale 1ns / 1ps

module html_escape_trim_encoder_top #(
    parameter int MAX_LEN     = 32,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    hesc_in_if.sink    in_ch,
    hesc_out_if.source out_ch
);

    logic           q_push;
    logic           q_full;
    logic           q_pop;
    logic           q_head_valid;
    hesc_pkg::cmd_t q_push_cmd;
    hesc_pkg::cmd_t q_head_cmd;

    hesc_front #(
        .MAX_LEN (MAX_LEN)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .q_full (q_full),
        .q_push (q_push),
        .q_cmd  (q_push_cmd)
    );

    hesc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_push_cmd),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (q_head_valid),
        .head_cmd   (q_head_cmd)
    );

    hesc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_head_valid),
        .cmd       (q_head_cmd),
        .cmd_pop   (q_pop),
        .out_ch    (out_ch)
    );

    // A command is never pushed into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
        else $error("command pushed into full queue");

    // A space transaction never queues a command.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready && in_ch.in_byte == hesc_pkg::CHR_SPACE) |-> !q_push)
        else $error("space produced a command");

    // Every other accepted byte queues exactly one command.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready && in_ch.in_byte != hesc_pkg::CHR_SPACE) |-> q_push)
        else $error("accepted byte produced no command");

    // The string end is a zero byte that closes its run.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.string_end) |->
        (out_ch.run_last && out_ch.out_byte == hesc_pkg::CHR_NUL))
        else $error("malformed string end");

endmodule

// ----- design/hesc_front.sv -----
// Front end: accepts input bytes, counts held-back spaces and queues commands.
`timescale 1ns / 1ps

module hesc_front #(
    parameter int MAX_LEN = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    hesc_in_if.sink        in_ch,
    input  logic           q_full,
    output logic           q_push,
    output hesc_pkg::cmd_t q_cmd
);

    logic [hesc_pkg::SPACE_W-1:0] pending_reg;
    logic [hesc_pkg::SPACE_W-1:0] pending_next;
    logic                         accept;

    assign in_ch.ready = !q_full;
    assign accept      = in_ch.valid && in_ch.ready;

    // Classify the accepted byte and build the command for the back end.
    always_comb
    begin
        pending_next  = pending_reg;
        q_push        = 1'b0;
        q_cmd.kind    = hesc_pkg::CMD_PLAIN;
        q_cmd.spaces  = pending_reg;
        q_cmd.data    = in_ch.in_byte;
        if (in_ch.in_byte == hesc_pkg::CHR_NUL)
        begin
            q_cmd.kind   = hesc_pkg::CMD_END;
            q_cmd.spaces = '0;
        end
        else if (hesc_pkg::is_special(in_ch.in_byte))
        begin
            q_cmd.kind = hesc_pkg::CMD_ENTITY;
        end
        if (accept)
        begin
            if (in_ch.in_byte == hesc_pkg::CHR_SPACE)
            begin
                // A space is only counted; the count saturates at the limit.
                if (pending_reg < hesc_pkg::SPACE_W'(MAX_LEN))
                begin
                    pending_next = pending_reg + 1'b1;
                end
            end
            else
            begin
                q_push       = 1'b1;
                pending_next = '0;
            end
        end
    end

    // Held-back space count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

endmodule

// ----- design/hesc_fifo.sv -----
// Command queue between the front end and the back end.
`timescale 1ns / 1ps

module hesc_fifo #(
    parameter int DEPTH = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  hesc_pkg::cmd_t push_cmd,
    input  logic           pop,
    output logic           full,
    output logic           head_valid,
    output hesc_pkg::cmd_t head_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    hesc_pkg::cmd_t   slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Storage slots.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- design/hesc_back.sv -----
// Back end: expands each queued command into spaces and escaped bytes, one per cycle while the output is ready.
`timescale 1ns / 1ps

module hesc_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    input  hesc_pkg::cmd_t cmd,
    output logic           cmd_pop,
    hesc_out_if.source     out_ch
);

    logic [hesc_pkg::SPACE_W-1:0] sp_reg;
    logic [hesc_pkg::SPACE_W-1:0] sp_next;
    logic [2:0]                   idx_reg;
    logic [2:0]                   idx_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [7:0]                   out_byte_reg;
    logic                         out_last_reg;
    logic                         out_end_reg;
    logic                         load;
    logic                         done;
    logic [7:0]                   emit_byte;
    logic                         emit_last;
    logic                         emit_end;

    assign load = cmd_valid && (!out_valid_reg || out_ch.ready);

    // Pick the next byte of the current command.
    always_comb
    begin
        emit_byte = hesc_pkg::CHR_SPACE;
        emit_last = 1'b0;
        emit_end  = 1'b0;
        done      = 1'b0;
        sp_next   = sp_reg;
        idx_next  = idx_reg;
        case (cmd.kind)
            hesc_pkg::CMD_PLAIN, hesc_pkg::CMD_ENTITY:
            begin
                if (sp_reg < cmd.spaces)
                begin
                    emit_byte = hesc_pkg::CHR_SPACE;
                    sp_next   = sp_reg + 1'b1;
                end
                else if (cmd.kind == hesc_pkg::CMD_ENTITY)
                begin
                    emit_byte = hesc_pkg::entity_byte(cmd.data, idx_reg);
                    if (idx_reg == hesc_pkg::entity_len(cmd.data) - 3'd1)
                    begin
                        emit_last = 1'b1;
                        done      = 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
                else
                begin
                    emit_byte = cmd.data;
                    emit_last = 1'b1;
                    done      = 1'b1;
                end
            end
            default:
            begin
                // String end: a single zero byte.
                emit_byte = hesc_pkg::CHR_NUL;
                emit_last = 1'b1;
                emit_end  = 1'b1;
                done      = 1'b1;
            end
        endcase
        if (done)
        begin
            sp_next  = '0;
            idx_next = '0;
        end
        if (!load)
        begin
            sp_next  = sp_reg;
            idx_next = idx_reg;
        end
    end

    assign cmd_pop        = load && done;
    assign out_valid_next = load ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_reg);

    // Progress counters within the current command and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg        <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sp_reg        <= sp_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg <= emit_byte;
            out_last_reg <= emit_last;
            out_end_reg  <= emit_end;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.out_byte   = out_byte_reg;
    assign out_ch.run_last   = out_last_reg;
    assign out_ch.string_end = out_end_reg;

endmodule
